// File: hdl/chti_pkg.sv
// Shared types, codes and saturation helper for the cubic Hermite table interpolator.
// Depends on nothing; every other file of the block but chti_ram imports it.
`default_nettype none

package chti_pkg;

  localparam int MAX_ADDR_BITS = 12;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_INSIDE = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  localparam logic [2:0] CFG_FIRST_POSITION  = 3'd0;
  localparam logic [2:0] CFG_GRID_SPACING    = 3'd1;
  localparam logic [2:0] CFG_INVERSE_SPACING = 3'd2;
  localparam logic [2:0] CFG_POINTS_IN_USE   = 3'd3;
  localparam logic [2:0] CFG_VALUE_GAIN      = 3'd4;

  // 1.0 in Q16.16, at basis width
  localparam logic signed [20:0] ONE_Q = 21'sd65536;

  typedef struct packed {
    logic               kind;
    logic [7:0]         entry_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] sample_tangent;
    logic signed [31:0] query_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic signed [31:0] interpolated_slope;
    logic [1:0]         region;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] first_position;
    logic [30:0]        grid_spacing;
    logic [30:0]        inverse_spacing;
    logic [8:0]         points_in_use;
    logic signed [31:0] value_gain;
  } cfg_t;

  // Word carried from front to back through the queue
  typedef struct packed {
    logic                     kind;
    logic [1:0]               region;
    logic [MAX_ADDR_BITS-1:0] addr;
    logic signed [63:0]       x;
    logic [15:0]              t;
    logic [31:0]              wval;
    logic [31:0]              wtan;
  } qword_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v[71:31] == '0 || v[71:31] == '1) begin
      r = v[31:0];
    end else if (v[71]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7FFFFFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/cubic_hermite_table_interpolator.sv
// Cubic Hermite interpolator over a uniform Q16.16 table.
// Throughput: one item per cycle; the front takes an item each cycle while the queue has room.
// Loads write both table copies as they leave the queue and give no result.
// Reset clears configuration to its defaults, all valid flags and the queue;
// table contents are undefined until loaded.
`default_nettype none

module cubic_hermite_table_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  chti_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output chti_pkg::out_item_t  out_item_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import chti_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   push, pop, full, empty;
  qword_t push_data, head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_POSITION:  cfg_d.first_position  = cfg_data_i;
        CFG_GRID_SPACING:    cfg_d.grid_spacing    = cfg_data_i[30:0];
        CFG_INVERSE_SPACING: cfg_d.inverse_spacing = cfg_data_i[30:0];
        CFG_POINTS_IN_USE:   cfg_d.points_in_use   = cfg_data_i[8:0];
        CFG_VALUE_GAIN:      cfg_d.value_gain      = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_position  <= '0;
      cfg_q.grid_spacing    <= 31'd65536;
      cfg_q.inverse_spacing <= 31'd65536;
      cfg_q.points_in_use   <= 9'd2;
      cfg_q.value_gain      <= 32'sd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  chti_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .cfg_i(cfg_q),
    .push_o(push), .push_data_o(push_data), .full_i(full));

  chti_fifo #(.DEPTH(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .head_o(head), .full_o(full), .empty_o(empty));

  chti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .head_i(head), .empty_i(empty), .pop_o(pop),
    .cfg_i(cfg_q),
    .out_valid_o, .out_stall_i, .out_item_o);

endmodule

`default_nettype wire

// File: hdl/chti_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module chti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/chti_fifo.sv
// Short queue of words between the front and back parts.
// Depends on chti_pkg for the word type.
`default_nettype none

module chti_fifo #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  chti_pkg::qword_t     push_data_i,
  input  wire logic            pop_i,
  output chti_pkg::qword_t     head_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import chti_pkg::*;

  qword_t        mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// File: hdl/chti_front.sv
// Front part: accepts items, scales load words, locates the segment of a query.
// Depends on chti_pkg; feeds chti_fifo.
`default_nettype none

module chti_front #(
  parameter int TABLE_DEPTH = 256,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  chti_pkg::in_item_t   in_item_i,
  input  chti_pkg::cfg_t       cfg_i,
  output logic                 push_o,
  output chti_pkg::qword_t     push_data_o,
  input  wire logic            full_i
);
  import chti_pkg::*;

  localparam logic [12:0] DEPTH_W = 13'(TABLE_DEPTH);

  logic fe, accept, keep;

  // stage 1
  logic               f1_valid_q;
  logic               f1_kind_q;
  logic [7:0]         f1_idx_q;
  logic signed [31:0] f1_val_q, f1_tan_q;
  logic signed [32:0] f1_d_q, f1_d_d;

  // stage 2
  logic               f2_valid_q;
  logic               f2_kind_q;
  logic [7:0]         f2_idx_q;
  logic signed [63:0] f2_v_q, f2_v_d, f2_p_q, f2_p_d, f2_u_q;
  logic signed [64:0] u_full;

  // stage 3
  logic                     f3_valid_q;
  logic                     f3_kind_q;
  logic [1:0]               f3_region_q, f3_region_d;
  logic [MAX_ADDR_BITS-1:0] f3_addr_q, f3_addr_d;
  logic signed [63:0]       f3_x_q, f3_x_d;
  logic [15:0]              f3_t_q;
  logic signed [31:0]       f3_vw_q, f3_vw_d;
  logic signed [63:0]       f3_a_q, f3_a_d;
  logic [62:0]              f3_b_q, f3_b_d;
  logic                     f3_negp_q;

  logic [12:0]        ncl, nm1;
  logic [30:0]        seg;
  logic signed [63:0] vr;
  logic [63:0]        bb;
  logic signed [31:0] tw;

  assign fe         = !(f3_valid_q && full_i);
  assign in_stall_o = !fe;
  assign accept     = in_valid_i && fe;
  // drop loads aimed past the table
  assign keep       = (in_item_i.kind == KIND_EVAL) || (13'(in_item_i.entry_index) < DEPTH_W);

  assign f1_d_d = $signed({in_item_i.query_position[31], in_item_i.query_position})
                - $signed({cfg_i.first_position[31], cfg_i.first_position});

  assign f2_v_d = f1_val_q * cfg_i.value_gain;
  assign f2_p_d = f1_tan_q * cfg_i.value_gain;
  assign u_full = f1_d_q * $signed({1'b0, cfg_i.inverse_spacing});

  assign f3_a_d = $signed(f2_p_q[63:32]) * $signed({1'b0, cfg_i.grid_spacing});
  assign f3_b_d = 63'(f2_p_q[31:0]) * 63'(cfg_i.grid_spacing);
  assign vr     = f2_v_q + 64'sh8000 - $signed({63'd0, f2_v_q[63]});
  assign f3_vw_d = sat32(72'($signed(vr[63:16])));

  always_comb begin
    if (13'(cfg_i.points_in_use) < 13'd2) begin
      ncl = 13'd2;
    end else if (13'(cfg_i.points_in_use) > DEPTH_W) begin
      ncl = DEPTH_W;
    end else begin
      ncl = 13'(cfg_i.points_in_use);
    end
    nm1 = ncl - 13'd1;
    seg = f2_u_q[62:32];
    if (f2_u_q[63]) begin
      f3_region_d = REGION_BELOW;
      f3_addr_d   = '0;
      f3_x_d      = f2_u_q;
    end else if (seg >= 31'(nm1)) begin
      f3_region_d = REGION_ABOVE;
      f3_addr_d   = nm1[MAX_ADDR_BITS-1:0];
      f3_x_d      = {f2_u_q[63:32] - 32'(nm1), f2_u_q[31:0]};
    end else begin
      f3_region_d = REGION_INSIDE;
      f3_addr_d   = MAX_ADDR_BITS'(seg[AW-1:0]);
      f3_x_d      = f2_u_q;
    end
    if (f2_kind_q == KIND_LOAD) begin
      f3_addr_d = MAX_ADDR_BITS'(f2_idx_q);
    end
  end

  // round the per-segment tangent by 2^32, half away from zero
  assign bb = {1'b0, f3_b_q} + 64'h80000000 - 64'(f3_negp_q);
  assign tw = sat32(72'(f3_a_q) + 72'($signed({1'b0, bb[63:32]})));

  assign push_o = f3_valid_q && !full_i;
  always_comb begin
    push_data_o.kind   = f3_kind_q;
    push_data_o.region = f3_region_q;
    push_data_o.addr   = f3_addr_q;
    push_data_o.x      = f3_x_q;
    push_data_o.t      = f3_t_q;
    push_data_o.wval   = f3_vw_q;
    push_data_o.wtan   = tw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else if (fe) begin
      f1_valid_q <= accept && keep;
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      f1_kind_q   <= in_item_i.kind;
      f1_idx_q    <= in_item_i.entry_index;
      f1_val_q    <= in_item_i.sample_value;
      f1_tan_q    <= in_item_i.sample_tangent;
      f1_d_q      <= f1_d_d;
      f2_kind_q   <= f1_kind_q;
      f2_idx_q    <= f1_idx_q;
      f2_v_q      <= f2_v_d;
      f2_p_q      <= f2_p_d;
      f2_u_q      <= u_full[63:0];
      f3_kind_q   <= f2_kind_q;
      f3_region_q <= f3_region_d;
      f3_addr_q   <= f3_addr_d;
      f3_x_q      <= f3_x_d;
      f3_t_q      <= f2_u_q[31:16];
      f3_vw_q     <= f3_vw_d;
      f3_a_q      <= f3_a_d;
      f3_b_q      <= f3_b_d;
      f3_negp_q   <= f2_p_q[63];
    end
  end

endmodule

`default_nettype wire

// File: hdl/chti_back.sv
// Back part: table memories and the Hermite / extrapolation pipeline.
// Depends on chti_pkg and chti_ram; drains chti_fifo.
`default_nettype none

module chti_back #(
  parameter int TABLE_DEPTH = 256,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  chti_pkg::qword_t     head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  chti_pkg::cfg_t       cfg_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output chti_pkg::out_item_t  out_item_o
);
  import chti_pkg::*;

  logic          be, we;
  logic [AW-1:0] ra, rb;
  logic [31:0]   rd_va, rd_vb, rd_ma, rd_mb;

  assign be    = !(out_valid_o && out_stall_i);
  assign pop_o = be && !empty_i;
  assign we    = pop_o && (head_i.kind == KIND_LOAD);
  assign ra    = head_i.addr[AW-1:0];
  assign rb    = AW'(ra + 1'b1);

  chti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val_a (
    .clk_i, .we_i(we), .waddr_i(ra), .wdata_i(head_i.wval),
    .re_i(be), .raddr_i(ra), .rdata_o(rd_va));
  chti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_val_b (
    .clk_i, .we_i(we), .waddr_i(ra), .wdata_i(head_i.wval),
    .re_i(be), .raddr_i(rb), .rdata_o(rd_vb));
  chti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tan_a (
    .clk_i, .we_i(we), .waddr_i(ra), .wdata_i(head_i.wtan),
    .re_i(be), .raddr_i(ra), .rdata_o(rd_ma));
  chti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tan_b (
    .clk_i, .we_i(we), .waddr_i(ra), .wdata_i(head_i.wtan),
    .re_i(be), .raddr_i(rb), .rdata_o(rd_mb));

  // stage 1: table words arrive
  logic               s1_valid_q;
  logic [1:0]         s1_region_q;
  logic signed [63:0] s1_x_q;
  logic [15:0]        s1_t_q;
  logic signed [31:0] v0, v1, m0, m1;

  // stage 2
  logic               s2_valid_q;
  logic [1:0]         s2_region_q;
  logic [15:0]        s2_t_q;
  logic [16:0]        s2_t2_q;
  logic signed [63:0] s2_xh_q, xh, s2_so_q, so;
  logic signed [64:0] s2_xl_q, xl;
  logic               s2_negx_q;
  logic signed [31:0] s2_v0_q, s2_v1_q, s2_m0_q, s2_m1_q;
  logic signed [32:0] s2_dv_q, dv;
  logic [31:0]        tsq;
  logic [32:0]        t2_sum;

  // stage 3
  logic               s3_valid_q;
  logic [1:0]         s3_region_q;
  logic [15:0]        s3_t_q;
  logic [16:0]        s3_t2_q, s3_t3_q;
  logic signed [31:0] s3_v0_q, s3_v1_q, s3_m0_q, s3_m1_q;
  logic signed [32:0] s3_dv_q;
  logic signed [31:0] s3_oval_q, s3_oslope_q, oval, oslope;
  logic [33:0]        t3_sum;
  logic signed [65:0] xr, osum;
  logic signed [66:0] oval_full;
  logic signed [63:0] sr;

  // stage 4: basis
  logic               s4_valid_q;
  logic [1:0]         s4_region_q;
  logic signed [20:0] s4_h00_q, s4_h10_q, s4_h01_q, s4_h11_q, s4_d00_q, s4_d10_q, s4_d11_q;
  logic signed [20:0] h00, h10, h01, h11, d00, d10, d11, bt, bt2, bt3;
  logic signed [31:0] s4_v0_q, s4_v1_q, s4_m0_q, s4_m1_q;
  logic signed [32:0] s4_dv_q;
  logic signed [31:0] s4_oval_q, s4_oslope_q;

  // stage 5: products
  logic               s5_valid_q;
  logic [1:0]         s5_region_q;
  logic signed [52:0] s5_p0_q, s5_p1_q, s5_p2_q, s5_p3_q, s5_q1_q, s5_q2_q;
  logic signed [53:0] s5_q0_q;
  logic signed [31:0] s5_oval_q, s5_oslope_q;

  // stage 6: sums
  logic               s6_valid_q;
  logic [1:0]         s6_region_q;
  logic signed [55:0] s6_sd_q, sv, sd, svr;
  logic signed [31:0] s6_value_q, s6_oslope_q, ival;

  // stage 7: slope scaling
  logic               s7_valid_q;
  logic [1:0]         s7_region_q;
  logic signed [55:0] s7_sh_q, sh;
  logic [62:0]        s7_sl_q, sl;
  logic               s7_negd_q;
  logic signed [31:0] s7_value_q, s7_oslope_q, islope;
  logic [63:0]        bb;

  logic      out_valid_q;
  out_item_t out_q;

  assign v0 = rd_va;
  assign v1 = rd_vb;
  assign m0 = rd_ma;
  assign m1 = rd_mb;

  assign tsq    = 32'(s1_t_q) * 32'(s1_t_q);
  assign t2_sum = 33'(tsq) + 33'd32768;
  assign xh     = $signed(s1_x_q[63:32]) * m0;
  assign xl     = $signed({1'b0, s1_x_q[31:0]}) * m0;
  assign so     = m0 * $signed({1'b0, cfg_i.inverse_spacing});
  assign dv     = v0 - v1;

  assign t3_sum    = 34'(s2_t2_q) * 34'(s2_t_q) + 34'd32768;
  // extrapolate: v + round(x * m / 2^32)
  assign xr        = 66'(s2_xl_q) + 66'sh80000000 - $signed({65'd0, s2_negx_q});
  assign osum      = 66'(s2_xh_q) + 66'($signed(xr[65:32]));
  assign oval_full = 67'(s2_v0_q) + 67'(osum);
  assign oval      = sat32(72'(oval_full));
  assign sr        = s2_so_q + 64'sh8000 - $signed({63'd0, s2_so_q[63]});
  assign oslope    = sat32(72'($signed(sr[63:16])));

  assign bt  = $signed({5'd0, s3_t_q});
  assign bt2 = $signed({4'd0, s3_t2_q});
  assign bt3 = $signed({4'd0, s3_t3_q});
  assign h00 = bt3 + bt3 - (bt2 + bt2 + bt2) + ONE_Q;
  assign h10 = bt3 - (bt2 + bt2) + bt;
  assign h01 = (bt2 + bt2 + bt2) - (bt3 + bt3);
  assign h11 = bt3 - bt2;
  assign d00 = 21'sd6 * bt2 - 21'sd6 * bt;
  assign d10 = (bt2 + bt2 + bt2) - 21'sd4 * bt + ONE_Q;
  assign d11 = (bt2 + bt2 + bt2) - (bt + bt);

  assign sv   = 56'(s5_p0_q) + 56'(s5_p1_q) + 56'(s5_p2_q) + 56'(s5_p3_q);
  assign sd   = 56'(s5_q0_q) + 56'(s5_q1_q) + 56'(s5_q2_q);
  assign svr  = sv + 56'sh8000 - $signed({55'd0, sv[55]});
  assign ival = sat32(72'($signed(svr[55:16])));

  assign sh = $signed(s6_sd_q[55:32]) * $signed({1'b0, cfg_i.inverse_spacing});
  assign sl = 63'(s6_sd_q[31:0]) * 63'(cfg_i.inverse_spacing);

  assign bb     = {1'b0, s7_sl_q} + 64'h80000000 - 64'(s7_negd_q);
  assign islope = sat32(72'(s7_sh_q) + 72'($signed({1'b0, bb[63:32]})));

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (be) begin
      s1_valid_q  <= pop_o && (head_i.kind == KIND_EVAL);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      out_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      s1_region_q <= head_i.region;
      s1_x_q      <= head_i.x;
      s1_t_q      <= head_i.t;

      s2_region_q <= s1_region_q;
      s2_t_q      <= s1_t_q;
      s2_t2_q     <= t2_sum[32:16];
      s2_xh_q     <= xh;
      s2_xl_q     <= xl;
      s2_negx_q   <= s1_x_q[63] ^ m0[31];
      s2_so_q     <= so;
      s2_v0_q     <= v0;
      s2_v1_q     <= v1;
      s2_m0_q     <= m0;
      s2_m1_q     <= m1;
      s2_dv_q     <= dv;

      s3_region_q <= s2_region_q;
      s3_t_q      <= s2_t_q;
      s3_t2_q     <= s2_t2_q;
      s3_t3_q     <= t3_sum[32:16];
      s3_v0_q     <= s2_v0_q;
      s3_v1_q     <= s2_v1_q;
      s3_m0_q     <= s2_m0_q;
      s3_m1_q     <= s2_m1_q;
      s3_dv_q     <= s2_dv_q;
      s3_oval_q   <= oval;
      s3_oslope_q <= oslope;

      s4_region_q <= s3_region_q;
      s4_h00_q    <= h00;
      s4_h10_q    <= h10;
      s4_h01_q    <= h01;
      s4_h11_q    <= h11;
      s4_d00_q    <= d00;
      s4_d10_q    <= d10;
      s4_d11_q    <= d11;
      s4_v0_q     <= s3_v0_q;
      s4_v1_q     <= s3_v1_q;
      s4_m0_q     <= s3_m0_q;
      s4_m1_q     <= s3_m1_q;
      s4_dv_q     <= s3_dv_q;
      s4_oval_q   <= s3_oval_q;
      s4_oslope_q <= s3_oslope_q;

      s5_region_q <= s4_region_q;
      s5_p0_q     <= s4_h00_q * s4_v0_q;
      s5_p1_q     <= s4_h10_q * s4_m0_q;
      s5_p2_q     <= s4_h01_q * s4_v1_q;
      s5_p3_q     <= s4_h11_q * s4_m1_q;
      s5_q0_q     <= s4_d00_q * s4_dv_q;
      s5_q1_q     <= s4_d10_q * s4_m0_q;
      s5_q2_q     <= s4_d11_q * s4_m1_q;
      s5_oval_q   <= s4_oval_q;
      s5_oslope_q <= s4_oslope_q;

      s6_region_q <= s5_region_q;
      s6_sd_q     <= sd;
      s6_value_q  <= (s5_region_q == REGION_INSIDE) ? ival : s5_oval_q;
      s6_oslope_q <= s5_oslope_q;

      s7_region_q <= s6_region_q;
      s7_sh_q     <= sh;
      s7_sl_q     <= sl;
      s7_negd_q   <= s6_sd_q[55];
      s7_value_q  <= s6_value_q;
      s7_oslope_q <= s6_oslope_q;

      out_q.interpolated_value <= s7_value_q;
      out_q.interpolated_slope <= (s7_region_q == REGION_INSIDE) ? islope : s7_oslope_q;
      out_q.region             <= s7_region_q;
    end
  end

endmodule

`default_nettype wire
